[sv/evmc_pkg.sv]
// shared types and constants for the exhaust valve mode controller
package evmc_pkg;

    // valve mode codes
    typedef enum logic [1:0] {
        MODE_AUTO   = 2'd0,
        MODE_MILD   = 2'd1,
        MODE_CLOSED = 2'd2,
        MODE_OPEN   = 2'd3
    } t_mode;

    // configuration register indexes
    localparam logic [1:0] CFG_LINK_OK   = 2'd0;
    localparam logic [1:0] CFG_WARMUP    = 2'd1;
    localparam logic [1:0] CFG_DEBOUNCE  = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // command codes
    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_BUTTON = 1'b1;

    // reset values of the configuration registers
    localparam logic [7:0]  WARMUP_RESET   = 8'd3;
    localparam logic [15:0] DEBOUNCE_RESET = 16'd200;

    // threshold constants
    localparam logic [13:0] AUTO_RPM_LOW   = 14'd3000;
    localparam logic [13:0] AUTO_RPM_HIGH  = 14'd4000;
    localparam logic [13:0] MILD_RPM       = 14'd2500;
    localparam logic [13:0] IDLE_RPM       = 14'd50;
    localparam logic [6:0]  LOAD_LOW       = 7'd80;
    localparam logic [6:0]  LOAD_HIGH      = 7'd90;
    localparam logic [6:0]  THROTTLE_HIGH  = 7'd90;
    localparam logic [6:0]  THROTTLE_MILD  = 7'd50;
    localparam logic [7:0]  SPEED_HIGHWAY  = 8'd90;
    localparam logic [7:0]  SPEED_SLOW     = 8'd25;
    localparam logic signed [8:0] COOLANT_WARM = 9'sd50;

    // lamp blink periods
    localparam logic [2:0] BLINK_AUTO  = 3'd5;
    localparam logic [2:0] BLINK_MILD  = 3'd2;
    localparam logic [2:0] BLINK_SOLID = 3'd0;
    localparam logic [2:0] TIMER_MAX   = 3'd7;

endpackage

[sv/exhaust_valve_mode_controller.sv]
// exhaust valve mode controller: input register, decision logic, result register
//
// One word in, one word out. A word taken at the input is registered, then the
// tick rules or the button logic run on it and the result lands in the output
// register once that register is free, and a new word is accepted every cycle
// as long as the output side keeps taking results. The mode, held readings,
// press time and lamp state are updated in the same cycle the result is
// registered, which closes the only feedback loop. Configuration
// writes take effect at once; writing link_ok also resets the mode (automatic
// when the link is up, forced closed when it is down).
module exhaust_valve_mode_controller (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [evmc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [evmc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_command,
    input  logic [31:0]                       i_time_ms,
    input  logic                              i_sample_ok,
    input  logic [13:0]                       i_engine_rpm,
    input  logic [7:0]                        i_road_speed,
    input  logic [6:0]                        i_throttle_pct,
    input  logic [6:0]                        i_load_pct,
    input  logic signed [8:0]                 i_coolant_c,
    input  logic [15:0]                       i_run_seconds,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_valve_open,
    output logic                              o_lamp_on,
    output logic [1:0]                        o_mode
);
    import evmc_pkg::*;

    // configuration registers
    logic        r_link_ok;
    logic [7:0]  r_warmup;
    logic [15:0] r_debounce;

    // input stage
    logic               r_in_valid;
    logic               r_command;
    logic [31:0]        r_time_ms;
    logic               r_sample_ok;
    logic [13:0]        r_rpm_in;
    logic [7:0]         r_speed_in;
    logic [6:0]         r_throttle_in;
    logic [6:0]         r_load_in;
    logic signed [8:0]  r_coolant_in;
    logic [15:0]        r_runtime_in;

    // block state
    t_mode              r_mode;
    logic [13:0]        r_held_rpm;
    logic [7:0]         r_held_speed;
    logic [6:0]         r_held_throttle;
    logic [6:0]         r_held_load;
    logic signed [8:0]  r_held_coolant;
    logic [15:0]        r_held_runtime;
    logic [31:0]        r_last_press;
    logic [2:0]         r_lamp_timer;
    logic [2:0]         r_blink_period;
    logic               r_lamp_level;
    logic               r_valve_level;

    // output stage
    logic               r_out_valid;
    logic               r_out_valve;
    logic               r_out_lamp;
    logic [1:0]         r_out_mode;

    // next values
    logic               w_advance;
    t_mode              n_mode;
    logic [13:0]        n_held_rpm;
    logic [7:0]         n_held_speed;
    logic [6:0]         n_held_throttle;
    logic [6:0]         n_held_load;
    logic signed [8:0]  n_held_coolant;
    logic [15:0]        n_held_runtime;
    logic [2:0]         n_lamp_timer;
    logic [2:0]         n_blink_period;
    logic               n_lamp_level;
    logic               n_valve_level;
    logic               w_warm;
    logic               w_rule_open;
    t_mode              w_rule_mode;
    t_mode              w_press_mode;
    t_mode              w_lowest;
    logic [31:0]        w_elapsed;
    logic [1:0]         w_mode_inc;

    // handshake: the decision stage moves when the output register is free
    assign w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_out_valid = r_out_valid;
    assign o_valve_open = r_out_valve;
    assign o_lamp_on    = r_out_lamp;
    assign o_mode       = r_out_mode;

    // readings held for the rules, refreshed on good samples with the link up
    always_comb begin
        if (r_link_ok && r_sample_ok) begin
            n_held_rpm      = r_rpm_in;
            n_held_speed    = r_speed_in;
            n_held_throttle = r_throttle_in;
            n_held_load     = r_load_in;
            n_held_coolant  = r_coolant_in;
            n_held_runtime  = r_runtime_in;
        end else begin
            n_held_rpm      = r_held_rpm;
            n_held_speed    = r_held_speed;
            n_held_throttle = r_held_throttle;
            n_held_load     = r_held_load;
            n_held_coolant  = r_held_coolant;
            n_held_runtime  = r_held_runtime;
        end
    end

    // threshold rules for the valve
    always_comb begin
        w_warm      = n_held_runtime > {8'd0, r_warmup};
        w_rule_open = 1'b0;
        w_rule_mode = r_mode;
        unique case (r_mode)
            MODE_AUTO: begin
                if (w_warm) begin
                    if ((n_held_rpm > AUTO_RPM_LOW || n_held_load > LOAD_LOW ||
                         n_held_throttle > THROTTLE_HIGH) && n_held_speed < SPEED_HIGHWAY) begin
                        w_rule_open = 1'b1;
                    end else if ((n_held_rpm > AUTO_RPM_HIGH || n_held_load > LOAD_HIGH ||
                                  n_held_throttle > THROTTLE_HIGH) &&
                                 n_held_speed >= SPEED_HIGHWAY) begin
                        w_rule_open = 1'b1;
                    end else if (n_held_speed == 8'd0 && n_held_coolant > COOLANT_WARM) begin
                        w_rule_open = 1'b1;
                    end
                end
            end
            MODE_MILD: begin
                if (w_warm) begin
                    if ((n_held_rpm > MILD_RPM || n_held_load > LOAD_LOW ||
                         n_held_throttle > THROTTLE_MILD) && n_held_speed < SPEED_HIGHWAY) begin
                        w_rule_open = 1'b1;
                    end else if (n_held_speed < SPEED_SLOW) begin
                        w_rule_open = 1'b1;
                    end else if (n_held_speed >= SPEED_HIGHWAY) begin
                        // highway speed in mild mode drops back to automatic
                        w_rule_mode = MODE_AUTO;
                    end
                end
            end
            MODE_CLOSED: w_rule_open = 1'b0;
            MODE_OPEN:   w_rule_open = 1'b1;
            default:     w_rule_open = 1'b0;
        endcase
        // idle or cold engine with the link up keeps the valve open
        if (r_link_ok && (n_held_rpm < IDLE_RPM || n_held_runtime < {8'd0, r_warmup})) begin
            n_valve_level = 1'b1;
        end else begin
            n_valve_level = w_rule_open;
        end
    end

    // button: debounced mode advance with wrap and lower bound
    always_comb begin
        w_elapsed    = r_time_ms - r_last_press;
        w_lowest     = r_link_ok ? MODE_AUTO : MODE_CLOSED;
        w_mode_inc   = r_mode + 2'd1;
        w_press_mode = r_mode;
        if (w_elapsed > {16'd0, r_debounce}) begin
            if (w_mode_inc < w_lowest) begin
                w_press_mode = w_lowest;
            end else begin
                w_press_mode = t_mode'(w_mode_inc);
            end
        end
    end

    // lamp blinking, driven by the mode after the rules
    always_comb begin
        n_blink_period = r_blink_period;
        n_lamp_level   = r_lamp_level;
        if (r_lamp_timer > r_blink_period) begin
            n_lamp_timer = 3'd1;
            case (w_rule_mode)
                MODE_AUTO: begin
                    n_blink_period = BLINK_AUTO;
                    n_lamp_level   = !r_lamp_level;
                end
                MODE_MILD: begin
                    n_blink_period = BLINK_MILD;
                    n_lamp_level   = !r_lamp_level;
                end
                MODE_CLOSED: begin
                    n_blink_period = BLINK_SOLID;
                    n_lamp_level   = 1'b0;
                end
                default: begin
                    n_blink_period = BLINK_SOLID;
                    n_lamp_level   = 1'b1;
                end
            endcase
        end else if (r_lamp_timer < TIMER_MAX) begin
            n_lamp_timer = r_lamp_timer + 3'd1;
        end else begin
            n_lamp_timer = TIMER_MAX;
        end
    end

    // next mode by command
    always_comb begin
        if (r_command == CMD_BUTTON) begin
            n_mode = w_press_mode;
        end else begin
            n_mode = w_rule_mode;
        end
    end

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_command     <= i_command;
            r_time_ms     <= i_time_ms;
            r_sample_ok   <= i_sample_ok;
            r_rpm_in      <= i_engine_rpm;
            r_speed_in    <= i_road_speed;
            r_throttle_in <= i_throttle_pct;
            r_load_in     <= i_load_pct;
            r_coolant_in  <= i_coolant_c;
            r_runtime_in  <= i_run_seconds;
        end
    end

    // configuration and block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_ok       <= 1'b0;
            r_warmup        <= WARMUP_RESET;
            r_debounce      <= DEBOUNCE_RESET;
            r_mode          <= MODE_AUTO;
            r_held_rpm      <= '0;
            r_held_speed    <= '0;
            r_held_throttle <= '0;
            r_held_load     <= '0;
            r_held_coolant  <= '0;
            r_held_runtime  <= '0;
            r_last_press    <= '0;
            r_lamp_timer    <= '0;
            r_blink_period  <= '0;
            r_lamp_level    <= 1'b0;
            r_valve_level   <= 1'b1;
        end else begin
            if (w_advance) begin
                // a link write in the same cycle owns the mode
                if (!(i_cfg_we && i_cfg_index == CFG_LINK_OK)) begin
                    r_mode <= n_mode;
                end
                if (r_command == CMD_BUTTON) begin
                    r_last_press <= r_time_ms;
                end else begin
                    r_held_rpm      <= n_held_rpm;
                    r_held_speed    <= n_held_speed;
                    r_held_throttle <= n_held_throttle;
                    r_held_load     <= n_held_load;
                    r_held_coolant  <= n_held_coolant;
                    r_held_runtime  <= n_held_runtime;
                    r_valve_level   <= n_valve_level;
                    r_lamp_timer    <= n_lamp_timer;
                    r_blink_period  <= n_blink_period;
                    r_lamp_level    <= n_lamp_level;
                end
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_LINK_OK: begin
                        r_link_ok <= i_cfg_data[0];
                        r_mode    <= i_cfg_data[0] ? MODE_AUTO : MODE_CLOSED;
                    end
                    CFG_WARMUP:   r_warmup   <= i_cfg_data[7:0];
                    CFG_DEBOUNCE: r_debounce <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_mode <= n_mode;
            if (r_command == CMD_BUTTON) begin
                r_out_valve <= r_valve_level;
                r_out_lamp  <= r_lamp_level;
            end else begin
                r_out_valve <= n_valve_level;
                r_out_lamp  <= n_lamp_level;
            end
        end
    end

endmodule

[bench/valve_scoreboard_pkg.sv]
// scoreboard class: predicts and checks the valve controller results
package valve_scoreboard_pkg;
    import evmc_pkg::*;

    // one expected result word
    typedef struct packed {
        logic  valve_open;
        logic  lamp_on;
        t_mode mode;
    } t_valve_result;

    class valve_scoreboard;
        // copy of the configuration registers
        logic               link_up;
        logic [7:0]         warmup_s;
        logic [15:0]        debounce;
        // copy of the controller state
        t_mode              mode;
        logic [13:0]        held_rpm;
        logic [7:0]         held_speed;
        logic [6:0]         held_throttle;
        logic [6:0]         held_load;
        logic signed [8:0]  held_coolant;
        logic [15:0]        held_runtime;
        logic [31:0]        last_press;
        logic [2:0]         lamp_timer;
        logic [2:0]         blink_period;
        logic               lamp_level;
        logic               valve_level;
        // results still owed by the block, oldest first
        t_valve_result      expected_results[$];
        int                 errors;

        function new();
            link_up       = 1'b0;
            warmup_s      = WARMUP_RESET;
            debounce      = DEBOUNCE_RESET;
            mode          = MODE_AUTO;
            held_rpm      = '0;
            held_speed    = '0;
            held_throttle = '0;
            held_load     = '0;
            held_coolant  = '0;
            held_runtime  = '0;
            last_press    = '0;
            lamp_timer    = '0;
            blink_period  = '0;
            lamp_level    = 1'b0;
            valve_level   = 1'b1;
            errors        = 0;
        endfunction

        task report(string msg);
            $display("%0t mismatch: %s", $realtime, msg);
            errors++;
        endtask

        // register write; writing the link flag also resets the mode
        function void set_register(logic [1:0] index, logic [15:0] data);
            case (index)
                CFG_LINK_OK: begin
                    link_up = data[0];
                    mode    = data[0] ? MODE_AUTO : MODE_CLOSED;
                end
                CFG_WARMUP:   warmup_s = data[7:0];
                CFG_DEBOUNCE: debounce = data;
                default: ;
            endcase
        endfunction

        // threshold rules on the held readings; mild mode may drop to auto
        function logic valve_decision();
            logic open_now;
            logic warm;
            open_now = 1'b0;
            warm     = held_runtime > {8'd0, warmup_s};
            if (mode == MODE_AUTO && warm) begin
                if ((held_rpm > AUTO_RPM_LOW || held_load > LOAD_LOW ||
                     held_throttle > THROTTLE_HIGH) && held_speed < SPEED_HIGHWAY)
                    open_now = 1'b1;
                else if ((held_rpm > AUTO_RPM_HIGH || held_load > LOAD_HIGH ||
                          held_throttle > THROTTLE_HIGH) && held_speed >= SPEED_HIGHWAY)
                    open_now = 1'b1;
                else if (held_speed == 8'd0 && held_coolant > COOLANT_WARM)
                    open_now = 1'b1;
            end else if (mode == MODE_MILD && warm) begin
                if ((held_rpm > MILD_RPM || held_load > LOAD_LOW ||
                     held_throttle > THROTTLE_MILD) && held_speed < SPEED_HIGHWAY)
                    open_now = 1'b1;
                else if (held_speed < SPEED_SLOW)
                    open_now = 1'b1;
                else if (held_speed >= SPEED_HIGHWAY)
                    mode = MODE_AUTO;
            end else if (mode == MODE_CLOSED) begin
                open_now = 1'b0;
            end else if (mode == MODE_OPEN) begin
                open_now = 1'b1;
            end
            // idle engine or still warming up with the link up forces the valve open
            if ((held_rpm < IDLE_RPM || held_runtime < {8'd0, warmup_s}) && link_up)
                open_now = 1'b1;
            return open_now;
        endfunction

        // lamp blink timer, one step per tick
        function void advance_lamp();
            if (lamp_timer > blink_period) begin
                lamp_timer = '0;
                case (mode)
                    MODE_AUTO: begin
                        blink_period = BLINK_AUTO;
                        lamp_level   = ~lamp_level;
                    end
                    MODE_MILD: begin
                        blink_period = BLINK_MILD;
                        lamp_level   = ~lamp_level;
                    end
                    MODE_CLOSED: begin
                        blink_period = BLINK_SOLID;
                        lamp_level   = 1'b0;
                    end
                    default: begin
                        blink_period = BLINK_SOLID;
                        lamp_level   = 1'b1;
                    end
                endcase
            end
            if (lamp_timer < TIMER_MAX)
                lamp_timer = lamp_timer + 3'd1;
        endfunction

        // accepted input word: update the state copy and queue the result
        function void note_word(logic cmd, logic [31:0] now, logic sample_ok,
                                logic [13:0] rpm, logic [7:0] speed, logic [6:0] throttle,
                                logic [6:0] load, logic signed [8:0] coolant,
                                logic [15:0] run_s);
            t_valve_result want;
            logic [31:0]   elapsed;
            t_mode         stepped;
            if (cmd == CMD_TICK) begin
                if (link_up && sample_ok) begin
                    held_rpm      = rpm;
                    held_speed    = speed;
                    held_throttle = throttle;
                    held_load     = load;
                    held_coolant  = coolant;
                    held_runtime  = run_s;
                end
                valve_level = valve_decision();
                advance_lamp();
            end else begin
                // button, debounced on the wrapping time difference
                elapsed = now - last_press;
                if (elapsed > {16'd0, debounce}) begin
                    if (mode == MODE_OPEN)
                        stepped = MODE_AUTO;
                    else
                        stepped = t_mode'(mode + 2'd1);
                    if (!link_up && stepped < MODE_CLOSED)
                        stepped = MODE_CLOSED;
                    mode = stepped;
                end
                last_press = now;
            end
            want.valve_open = valve_level;
            want.lamp_on    = lamp_level;
            want.mode       = mode;
            expected_results.push_back(want);
        endfunction

        // accepted result word against the oldest expectation
        task check_result(logic valve_open, logic lamp_on, logic [1:0] mode_out);
            t_valve_result want;
            if (expected_results.size() == 0) begin
                report($sformatf("unexpected result valve %0b lamp %0b mode %0d",
                                 valve_open, lamp_on, mode_out));
                return;
            end
            want = expected_results.pop_front();
            if (valve_open !== want.valve_open)
                report($sformatf("valve_open %0b, want %0b", valve_open, want.valve_open));
            if (lamp_on !== want.lamp_on)
                report($sformatf("lamp_on %0b, want %0b", lamp_on, want.lamp_on));
            if (mode_out !== want.mode)
                report($sformatf("mode %0d, want %0d", mode_out, want.mode));
        endtask

        task flag_leftover();
            if (expected_results.size() != 0)
                report($sformatf("%0d results never arrived", expected_results.size()));
        endtask

        function int pending();
            return expected_results.size();
        endfunction
    endclass

endpackage

[bench/testbench.sv]
// top level bench for the exhaust valve mode controller
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import evmc_pkg::*;
    import valve_scoreboard_pkg::*;

    localparam int STALL_LIMIT     = 3000;
    localparam int DRAIN_CYCLES    = 4;
    localparam int ITEMS_PER_PHASE = 305;
    localparam int HOLD_CYCLES     = 40;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_ready;
    logic                  i_command      = 1'b0;
    logic [31:0]           i_time_ms      = '0;
    logic                  i_sample_ok    = 1'b0;
    logic [13:0]           i_engine_rpm   = '0;
    logic [7:0]            i_road_speed   = '0;
    logic [6:0]            i_throttle_pct = '0;
    logic [6:0]            i_load_pct     = '0;
    logic signed [8:0]     i_coolant_c    = '0;
    logic [15:0]           i_run_seconds  = '0;
    logic                  o_out_valid;
    logic                  i_out_ready    = 1'b0;
    logic                  o_valve_open;
    logic                  o_lamp_on;
    logic [1:0]            o_mode;

    valve_scoreboard results_board = new();

    int          send_idle_pct = 23;
    int          recv_idle_pct = 77;
    int          hold_request  = 0;
    int          hold_left     = 0;
    int          stall_cycles  = 0;
    logic [7:0]  cur_warmup    = WARMUP_RESET;
    logic [15:0] cur_debounce  = DEBOUNCE_RESET;
    logic [31:0] press_clock   = '0;

    exhaust_valve_mode_controller DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_time_ms      (i_time_ms),
        .i_sample_ok    (i_sample_ok),
        .i_engine_rpm   (i_engine_rpm),
        .i_road_speed   (i_road_speed),
        .i_throttle_pct (i_throttle_pct),
        .i_load_pct     (i_load_pct),
        .i_coolant_c    (i_coolant_c),
        .i_run_seconds  (i_run_seconds),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_valve_open   (o_valve_open),
        .o_lamp_on      (o_lamp_on),
        .o_mode         (o_mode)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: random stalls, plus a long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watch both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                results_board.note_word(i_command, i_time_ms, i_sample_ok, i_engine_rpm,
                                        i_road_speed, i_throttle_pct, i_load_pct,
                                        i_coolant_c, i_run_seconds);
            if (o_out_valid && i_out_ready)
                results_board.check_result(o_valve_open, o_lamp_on, o_mode);
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // offer one word, return at the edge where it is taken
    task automatic send_word(logic cmd, logic [31:0] t_ms, logic ok, logic [13:0] rpm,
                             logic [7:0] speed, logic [6:0] throttle, logic [6:0] load,
                             logic signed [8:0] coolant, logic [15:0] run_s);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_time_ms      <= t_ms;
        i_sample_ok    <= ok;
        i_engine_rpm   <= rpm;
        i_road_speed   <= speed;
        i_throttle_pct <= throttle;
        i_load_pct     <= load;
        i_coolant_c    <= coolant;
        i_run_seconds  <= run_s;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_tick(int ok, int rpm, int speed, int throttle, int load,
                             int coolant, int run_s);
        send_word(CMD_TICK, $urandom, (ok != 0), 14'(rpm), 8'(speed), 7'(throttle),
                  7'(load), 9'(coolant), 16'(run_s));
    endtask

    // sample fields of a press are ignored, so they carry noise
    task automatic send_press(logic [31:0] t_ms);
        send_word(CMD_BUTTON, t_ms, 1'($urandom_range(1)), 14'($urandom), 8'($urandom),
                  7'($urandom), 7'($urandom), 9'($urandom), 16'($urandom));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (results_board.pending() > 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] index, logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        results_board.set_register(index, data);
        i_cfg_we <= 1'b0;
    endtask

    task automatic configure(logic link, logic [7:0] warmup, logic [15:0] deb);
        wait_drained();
        cfg_write(CFG_LINK_OK, {15'd0, link});
        cfg_write(CFG_WARMUP, {8'd0, warmup});
        cfg_write(CFG_DEBOUNCE, deb);
        cur_warmup   = warmup;
        cur_debounce = deb;
    endtask

    function automatic int pick_near(int center, int spread, int lo, int hi);
        int v;
        v = center - spread + int'($urandom_range(2 * spread));
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        return v;
    endfunction

    // random word, biased toward the rule thresholds and the debounce edge
    task automatic send_random_word();
        int rpm;
        int speed;
        int throttle;
        int load;
        int coolant;
        int run_s;
        if ($urandom_range(99) < 15) begin
            case ($urandom_range(3))
                0: press_clock = press_clock + $urandom_range(cur_debounce);
                1: press_clock = press_clock + cur_debounce + 1 + $urandom_range(3);
                2: press_clock = press_clock + $urandom;
                default: press_clock = 32'hFFFF_FF00 + $urandom_range(255);
            endcase
            send_press(press_clock);
        end else begin
            case ($urandom_range(4))
                0: rpm = pick_near(int'(IDLE_RPM), 3, 0, 16383);
                1: rpm = pick_near(int'(MILD_RPM), 3, 0, 16383);
                2: rpm = pick_near(int'(AUTO_RPM_LOW), 3, 0, 16383);
                3: rpm = pick_near(int'(AUTO_RPM_HIGH), 3, 0, 16383);
                default: rpm = $urandom_range(16383);
            endcase
            case ($urandom_range(4))
                0: speed = $urandom_range(1);
                1: speed = pick_near(int'(SPEED_SLOW), 2, 0, 255);
                2: speed = pick_near(int'(SPEED_HIGHWAY), 2, 0, 255);
                default: speed = $urandom_range(255);
            endcase
            case ($urandom_range(2))
                0: throttle = pick_near(int'(THROTTLE_MILD), 1, 0, 100);
                1: throttle = pick_near(int'(THROTTLE_HIGH), 1, 0, 100);
                default: throttle = $urandom_range(100);
            endcase
            case ($urandom_range(2))
                0: load = pick_near(int'(LOAD_LOW), 1, 0, 100);
                1: load = pick_near(int'(LOAD_HIGH), 1, 0, 100);
                default: load = $urandom_range(100);
            endcase
            if ($urandom_range(1) == 0)
                coolant = pick_near(int'(COOLANT_WARM), 1, -40, 215);
            else
                coolant = -40 + int'($urandom_range(255));
            case ($urandom_range(2))
                0: run_s = pick_near(int'(cur_warmup), 1, 0, 65535);
                1: run_s = $urandom_range(300);
                default: run_s = $urandom_range(65535);
            endcase
            send_tick(int'($urandom_range(9) != 0), rpm, speed, throttle, load, coolant,
                      run_s);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // link down after reset: readings are not held, presses floor at closed
        send_tick(1, 5000, 50, 95, 95, 100, 1000);
        send_press(32'd100);
        send_press(32'd300);
        send_press(32'd501);
        send_press(32'd800);
        send_tick(1, 5000, 50, 95, 95, 100, 1000);

        // link up, no debounce
        configure(1'b1, 8'd10, 16'd0);
        send_tick(0, 16383, 255, 100, 100, 215, 65535);
        send_tick(1, 16383, 255, 100, 100, 215, 65535);
        send_tick(1, 0, 0, 0, 0, -40, 0);
        send_tick(1, 3500, 50, 0, 0, 20, 10);
        send_tick(1, 1000, 0, 0, 0, 51, 100);
        send_tick(1, 1000, 0, 0, 0, 50, 100);
        send_tick(1, 3500, 100, 0, 0, 20, 100);
        // into mild, then a repeated press with no time passed
        send_press(32'hFFFF_FFF0);
        send_press(32'hFFFF_FFF0);
        send_tick(1, 2600, 50, 0, 0, 20, 100);
        send_tick(1, 100, 10, 0, 0, 20, 100);
        send_tick(1, 100, 60, 0, 0, 20, 100);
        // highway speed drops mild back to auto
        send_tick(1, 100, 90, 0, 0, 20, 100);
        // press time wraps; walk through every mode
        send_press(32'h0000_0010);
        send_press(32'h0000_0020);
        send_tick(1, 5000, 50, 100, 100, 100, 100);
        send_press(32'h0000_0030);
        send_tick(1, 5000, 50, 100, 100, 100, 100);
        send_press(32'h0000_0040);
        send_tick(1, 5000, 50, 100, 100, 100, 100);
        press_clock = 32'h0000_0040;

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: configure(1'b1, 8'd3, 16'd200);
                1: configure(1'b1, 8'd0, 16'd0);
                2: configure(1'b1, 8'd255, 16'd65535);
                3: configure(1'b0, 8'd3, 16'd200);
                4: configure(1'b1, 8'd20, 16'd1000);
                default: configure(1'b1, 8'd5, 16'd50);
            endcase
            if (phase < 2) begin
                send_idle_pct = 23;
                recv_idle_pct = 77;
            end else if (phase < 4) begin
                send_idle_pct = 77;
                recv_idle_pct = 23;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // output held off long enough to back up the input
                if (n == ITEMS_PER_PHASE / 2)
                    hold_request = HOLD_CYCLES;
                // sender goes quiet until every result is back
                if (phase == 2 && n == 100)
                    wait_drained();
                send_random_word();
            end
        end

        wait_drained();
        results_board.flag_leftover();
        if (results_board.errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
